// ----- rtl/srbm_pkg.sv -----
// Package for the stream buffer ring manager: sizes, codes, entry layout
// and the pointer wrap helper. No dependencies.
`timescale 1ns / 1ps
package srbm_pkg;

  localparam int CLIENTS     = 16;
  localparam int BUFFERS_MAX = 16;
  localparam int CLIENT_W    = 4;
  localparam int PTR_W       = 4;
  localparam int CNT_W       = 5;
  localparam int ADDR_W      = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  // Register map: byte address bit 2 selects the register index
  localparam logic REG_BUFFER_COUNT = 1'b0;
  localparam logic [CNT_W-1:0] BUFFER_COUNT_RST = CNT_W'(4);

  typedef enum logic [1:0] {
    OP_OPEN     = 2'd0,
    OP_CONTINUE = 2'd1,
    OP_CLOSE    = 2'd2,
    OP_FEEDBACK = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OPENING = 2'd0,
    STAT_OPEN    = 2'd1,
    STAT_CLOSING = 2'd2,
    STAT_CLOSED  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OC_DONE    = 2'd0,
    OC_REFUSED = 2'd1,
    OC_ERROR   = 2'd2
  } outcome_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } ctrl_state_e;

  // Per-client ring state as held in the state memory
  typedef struct packed {
    status_e          status;
    logic [PTR_W-1:0] dptr;
    logic [PTR_W-1:0] rptr;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t ENTRY_RST = '{status: STAT_CLOSED, dptr: '0, rptr: '0, cnt: '0};

  // Advance a ring pointer, wrapping at ring size n
  function automatic logic [PTR_W-1:0] ptr_advance(logic [PTR_W-1:0] p,
                                                    logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] q;
    q = CNT_W'(p) + CNT_W'(1);
    return (q >= n) ? '0 : q[PTR_W-1:0];
  endfunction

endpackage

// ----- rtl/srbm_ifs.sv -----
// Request and response channel interfaces of the stream buffer ring manager.
// Depends on srbm_pkg for field widths.
`timescale 1ns / 1ps
interface srbm_req_if;
  import srbm_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic [CLIENT_W-1:0] client;
  logic [PTR_W-1:0]    returned_buffer;

  modport source (output valid, operation, client, returned_buffer, input ready);
  modport sink (input valid, operation, client, returned_buffer, output ready);
endinterface

interface srbm_rsp_if;
  import srbm_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       outcome;
  logic             buffer_valid;
  logic [PTR_W-1:0] buffer_index;
  logic             processed_valid;
  logic [PTR_W-1:0] processed_index;
  logic [1:0]       client_status;
  logic [CNT_W-1:0] outstanding;

  modport source (output valid, outcome, buffer_valid, buffer_index, processed_valid,
                  processed_index, client_status, outstanding, input ready);
  modport sink (input valid, outcome, buffer_valid, buffer_index, processed_valid,
                processed_index, client_status, outstanding, output ready);
endinterface

// ----- rtl/srbm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module srbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/stream_buffer_ring_manager_core.sv -----
// Top level of the stream buffer ring manager: control, per-client state
// memory and APB register. Depends on srbm_pkg, srbm_ifs and srbm_ram.
`timescale 1ns / 1ps
// Usage:
//   req_i carries one request per handshake (operation, client,
//   returned_buffer); rsp_o returns exactly one result per request, in order.
//   The APB port holds buffer_count (byte address 0), the ring size per
//   client; write it only while no request is in flight.
// Sequencing:
//   A request first reads the client's entry from the state memory, then
//   updates it and loads the result register.
//   The next request is taken in the cycle after the update, so requests
//   do not overlap; while the output register is full, the update waits.
//   A result appears on rsp_o from the output register once its update is done.
// Reset:
//   All clients read as closed with zero pointers and count, by a valid bit
//   per client; no clearing pass is needed. buffer_count returns to 4.
// Stalls:
//   A result waits in the output register while rsp_o.ready is low; one more
//   request is read meanwhile and then holds until the register frees up.
module stream_buffer_ring_manager_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  srbm_req_if.sink                      req_i,
  srbm_rsp_if.source                    rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srbm_pkg::PADDR_W-1:0]  paddr,
  input  logic [srbm_pkg::PDATA_W-1:0]  pwdata,
  output logic [srbm_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import srbm_pkg::*;

  ctrl_state_e state_q, state_d;

  logic [CNT_W-1:0]    buffer_count_q;
  logic [CLIENTS-1:0]  valid_q;
  op_e                 op_q;
  logic [CLIENT_W-1:0] client_q;
  logic [PTR_W-1:0]    ret_q;

  logic               accept;
  logic               out_free;
  logic               commit;
  logic               client_ok;
  logic [ADDR_W-1:0]  entry_addr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             cur;
  entry_t             nxt;
  logic [CNT_W-1:0]   ring_n;

  outcome_e         res_outcome;
  logic             res_bv;
  logic [PTR_W-1:0] res_bi;
  logic             res_pv;
  logic [PTR_W-1:0] res_pi;
  status_e          res_status;
  logic [CNT_W-1:0] res_cnt;

  logic             rsp_valid_q;
  outcome_e         rsp_outcome_q;
  logic             rsp_bv_q;
  logic [PTR_W-1:0] rsp_bi_q;
  logic             rsp_pv_q;
  logic [PTR_W-1:0] rsp_pi_q;
  status_e          rsp_status_q;
  logic [CNT_W-1:0] rsp_cnt_q;

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BUFFER_COUNT) ? PDATA_W'(buffer_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_count_q <= BUFFER_COUNT_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_BUFFER_COUNT) begin
      buffer_count_q <= pwdata[CNT_W-1:0];
    end
  end

  // Clamp ring size to 1..BUFFERS_MAX
  always_comb begin
    if (buffer_count_q == '0) begin
      ring_n = CNT_W'(1);
    end else if (buffer_count_q > CNT_W'(BUFFERS_MAX)) begin
      ring_n = CNT_W'(BUFFERS_MAX);
    end else begin
      ring_n = buffer_count_q;
    end
  end

  // Handshake qualifiers
  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !rsp_valid_q || rsp_o.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    req_i.ready = 1'b0;
    commit      = 1'b0;
    case (state_q)
      S_IDLE:  req_i.ready = 1'b1;
      S_EXEC:  commit = out_free;
      default: begin
        req_i.ready = 1'b0;
        commit      = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_e'(req_i.operation);
      client_q <= req_i.client;
      ret_q    <= req_i.returned_buffer;
    end
  end

  assign entry_addr = client_q[ADDR_W-1:0];
  assign client_ok  = int'(client_q) < CLIENTS;

  // Per-client state memory
  srbm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CLIENTS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (commit && client_ok),
    .waddr_i (entry_addr),
    .wdata_i (nxt),
    .re_i    (accept),
    .raddr_i (req_i.client[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Mark entries written since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (commit && client_ok) begin
      valid_q[entry_addr] <= 1'b1;
    end
  end

  // Unwritten entries read as the reset value
  assign cur = valid_q[entry_addr] ? entry_t'(ram_rdata) : ENTRY_RST;

  // Modify: apply the request to the client's entry
  always_comb begin
    nxt         = cur;
    res_outcome = OC_DONE;
    res_bv      = 1'b0;
    res_bi      = '0;
    res_pv      = 1'b0;
    res_pi      = '0;
    case (op_q)
      OP_OPEN: begin
        if (cur.status == STAT_CLOSING && cur.cnt != '0) begin
          nxt.status = STAT_OPEN;
        end else if (cur.status inside {STAT_CLOSING, STAT_CLOSED}) begin
          nxt = '{status: STAT_OPENING, dptr: '0, rptr: '0, cnt: '0};
        end else begin
          res_outcome = OC_REFUSED;
        end
      end
      OP_CONTINUE: begin
        if (cur.status == STAT_OPENING) begin
          res_bv     = 1'b1;
          nxt.dptr   = ptr_advance('0, ring_n);
          nxt.rptr   = '0;
          nxt.cnt    = CNT_W'(1);
          nxt.status = STAT_OPEN;
        end else if (cur.status == STAT_OPEN && cur.cnt < ring_n) begin
          res_bv   = 1'b1;
          res_bi   = cur.dptr;
          nxt.dptr = ptr_advance(cur.dptr, ring_n);
          nxt.cnt  = cur.cnt + CNT_W'(1);
        end else begin
          res_outcome = OC_REFUSED;
        end
      end
      OP_CLOSE: begin
        if (cur.status == STAT_OPENING) begin
          nxt.status = STAT_CLOSED;
        end else if (cur.status == STAT_OPEN) begin
          nxt.status = (cur.cnt != '0) ? STAT_CLOSING : STAT_CLOSED;
        end else begin
          res_outcome = OC_ERROR;
        end
      end
      OP_FEEDBACK: begin
        if (!(cur.status inside {STAT_OPEN, STAT_CLOSING}) || cur.cnt == '0 ||
            ret_q != cur.rptr || (cur.status == STAT_OPEN && cur.cnt == CNT_W'(1))) begin
          res_outcome = OC_ERROR;
        end else begin
          res_pv   = 1'b1;
          res_pi   = cur.rptr;
          nxt.rptr = ptr_advance(cur.rptr, ring_n);
          nxt.cnt  = cur.cnt - CNT_W'(1);
          if (cur.cnt == CNT_W'(1)) nxt.status = STAT_CLOSED;
        end
      end
      default: res_outcome = OC_ERROR;
    endcase
    res_status = nxt.status;
    res_cnt    = nxt.cnt;
    // Drop requests for clients beyond the table
    if (!client_ok) begin
      res_outcome = OC_ERROR;
      res_bv      = 1'b0;
      res_bi      = '0;
      res_pv      = 1'b0;
      res_pi      = '0;
      res_status  = STAT_CLOSED;
      res_cnt     = '0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (commit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      rsp_outcome_q <= res_outcome;
      rsp_bv_q      <= res_bv;
      rsp_bi_q      <= res_bi;
      rsp_pv_q      <= res_pv;
      rsp_pi_q      <= res_pi;
      rsp_status_q  <= res_status;
      rsp_cnt_q     <= res_cnt;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.outcome         = rsp_outcome_q;
  assign rsp_o.buffer_valid    = rsp_bv_q;
  assign rsp_o.buffer_index    = rsp_bi_q;
  assign rsp_o.processed_valid = rsp_pv_q;
  assign rsp_o.processed_index = rsp_pi_q;
  assign rsp_o.client_status   = rsp_status_q;
  assign rsp_o.outstanding     = rsp_cnt_q;

endmodule

// ----- tb/sv/tb_stream_buffer_ring_manager_core.sv -----
// Self-checking testbench for stream_buffer_ring_manager_core: directed and random
// open/continue/close/feedback requests checked against an in-bench ring predictor.
// Depends on srbm_pkg, srbm_ifs and the core RTL.
`timescale 1ns / 1ps
module tb_stream_buffer_ring_manager_core;
  import srbm_pkg::*;

  localparam logic [PADDR_W-1:0] RING_SIZE_ADDR = {REG_BUFFER_COUNT, 2'b00};
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 235;

  typedef struct packed {
    op_e              op;
    logic [CLIENT_W-1:0] client;
    logic [PTR_W-1:0] ret;
  } ring_req_t;

  typedef struct packed {
    outcome_e         outcome;
    logic             buf_vld;
    logic [PTR_W-1:0] buf_idx;
    logic             proc_vld;
    logic [PTR_W-1:0] proc_idx;
    status_e          status;
    logic [CNT_W-1:0] held;
  } ring_rsp_t;

  typedef struct packed {
    status_e          status;
    logic [PTR_W-1:0] dptr;
    logic [PTR_W-1:0] rptr;
    logic [CNT_W-1:0] held;
  } ring_state_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  srbm_req_if req_bus ();
  srbm_rsp_if rsp_bus ();

  // Ring state as seen at request acceptance, and as planned by the generator
  ring_state_t      live_ring [CLIENTS];
  ring_state_t      plan_ring [CLIENTS];
  logic [CNT_W-1:0] live_cfg;
  logic [CNT_W-1:0] plan_cfg;

  ring_req_t pending_reqs [$];
  ring_rsp_t expected_rsps [$];
  int        mismatches = 0;
  int        tx_gap = 0;
  int        rx_stall = 0;
  logic      tx_idle;
  logic      rx_idle;

  stream_buffer_ring_manager_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Clamp the programmed ring size to the supported range
  function automatic logic [CNT_W-1:0] ring_size(input logic [CNT_W-1:0] cfg);
    if (cfg == '0) return CNT_W'(1);
    if (cfg > CNT_W'(BUFFERS_MAX)) return CNT_W'(BUFFERS_MAX);
    return cfg;
  endfunction

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] q;
    q = {1'b0, p} + CNT_W'(1);
    return (q >= n) ? '0 : q[PTR_W-1:0];
  endfunction

  // Apply one request to a client's ring and form the result it produces
  task automatic serve_request(input ring_req_t r, input logic [CNT_W-1:0] cfg,
                               inout ring_state_t s, output ring_rsp_t o);
    logic [CNT_W-1:0] n;
    n          = ring_size(cfg);
    o.outcome  = OC_DONE;
    o.buf_vld  = 1'b0;
    o.buf_idx  = '0;
    o.proc_vld = 1'b0;
    o.proc_idx = '0;
    case (r.op)
      OP_OPEN: begin
        if (s.status == STAT_CLOSING && s.held != '0) begin
          s.status = STAT_OPEN;
        end else if (s.status == STAT_CLOSING || s.status == STAT_CLOSED) begin
          s.status = STAT_OPENING;
          s.dptr   = '0;
          s.rptr   = '0;
          s.held   = '0;
        end else begin
          o.outcome = OC_REFUSED;
        end
      end
      OP_CONTINUE: begin
        if (s.status == STAT_OPENING) begin
          o.buf_vld = 1'b1;
          s.dptr    = next_slot('0, n);
          s.rptr    = '0;
          s.held    = CNT_W'(1);
          s.status  = STAT_OPEN;
        end else if (s.status == STAT_OPEN && s.held < n) begin
          o.buf_vld = 1'b1;
          o.buf_idx = s.dptr;
          s.dptr    = next_slot(s.dptr, n);
          s.held    = s.held + CNT_W'(1);
        end else begin
          o.outcome = OC_REFUSED;
        end
      end
      OP_CLOSE: begin
        if (s.status == STAT_OPENING) begin
          s.status = STAT_CLOSED;
        end else if (s.status == STAT_OPEN) begin
          s.status = (s.held != '0) ? STAT_CLOSING : STAT_CLOSED;
        end else begin
          o.outcome = OC_ERROR;
        end
      end
      default: begin
        // Only the oldest buffer may come back, and never the last one of an open stream
        if ((s.status == STAT_OPEN || s.status == STAT_CLOSING) && s.held != '0 &&
            r.ret == s.rptr && !(s.status == STAT_OPEN && s.held == CNT_W'(1))) begin
          o.proc_vld = 1'b1;
          o.proc_idx = s.rptr;
          s.rptr     = next_slot(s.rptr, n);
          s.held     = s.held - CNT_W'(1);
          if (s.held == '0) s.status = STAT_CLOSED;
        end else begin
          o.outcome = OC_ERROR;
        end
      end
    endcase
    o.status = s.status;
    o.held   = s.held;
  endtask

  // Queue a request and advance the generator's view of the rings
  task automatic push_req(input op_e op, input int client, input int ret);
    ring_req_t r;
    ring_rsp_t unused;
    r.op     = op;
    r.client = CLIENT_W'(client);
    r.ret    = PTR_W'(ret);
    serve_request(r, plan_cfg, plan_ring[r.client], unused);
    pending_reqs = {pending_reqs, r};
  endtask

  // Mostly well-formed stream sequences on a few busy clients, plus noise
  task automatic pick_request();
    int          c;
    int          roll;
    ring_state_t s;
    op_e         op;
    int          ret;
    c    = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 3) : $urandom_range(0, CLIENTS - 1);
    s    = plan_ring[c];
    roll = $urandom_range(0, 99);
    ret  = $urandom_range(0, 15);
    if ($urandom_range(0, 99) < 8) begin
      op = op_e'($urandom_range(0, 3));
    end else begin
      case (s.status)
        STAT_CLOSED:  op = OP_OPEN;
        STAT_OPENING: op = (roll < 85) ? OP_CONTINUE : OP_CLOSE;
        STAT_OPEN: begin
          if (s.held < ring_size(plan_cfg) && roll < 50) op = OP_CONTINUE;
          else if (s.held > CNT_W'(1) && roll < 88) op = OP_FEEDBACK;
          else if (roll < 94) op = OP_CONTINUE;
          else op = OP_CLOSE;
        end
        default:      op = (roll < 88) ? OP_FEEDBACK : OP_OPEN;
      endcase
      if (op == OP_FEEDBACK && $urandom_range(0, 99) < 92) ret = s.rptr;
    end
    push_req(op, c, ret);
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || req_bus.valid || expected_rsps.size() != 0)
      @(negedge clk_i);
  endtask

  // Write the ring size register: setup cycle, then access cycle
  task automatic write_ring_size(input logic [CNT_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RING_SIZE_ADDR;
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    live_cfg = value;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Drive requests from the pending queue, with a random gap after each one while tx_idle is set
  always @(posedge clk_i) begin : drive_requests
    ring_req_t nxt;
    ring_rsp_t want;
    logic      hold;
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      hold = req_bus.valid;
      if (req_bus.valid && req_bus.ready) begin
        nxt.op     = op_e'(req_bus.operation);
        nxt.client = req_bus.client;
        nxt.ret    = req_bus.returned_buffer;
        serve_request(nxt, live_cfg, live_ring[nxt.client], want);
        expected_rsps = {expected_rsps, want};
        tx_gap = tx_idle ? $urandom_range(0, 4) : 0;
        hold   = 1'b0;
      end
      if (!hold) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_reqs.size() != 0) begin
          nxt = pending_reqs.pop_front();
          req_bus.operation       <= nxt.op;
          req_bus.client          <= nxt.client;
          req_bus.returned_buffer <= nxt.ret;
          hold = 1'b1;
        end
      end
      req_bus.valid <= hold;
    end
  end

  // Accept results, with random stalls while rx_idle is set, and compare against the oldest expectation
  always @(posedge clk_i) begin : check_results
    ring_rsp_t want;
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t ns: unexpected result, expected none actual outcome %0d status %0d",
                   $time, rsp_bus.outcome, rsp_bus.client_status);
          mismatches++;
        end else begin
          want = expected_rsps.pop_front();
          check_field("outcome", want.outcome, rsp_bus.outcome);
          check_field("buffer_valid", want.buf_vld, rsp_bus.buffer_valid);
          check_field("buffer_index", want.buf_idx, rsp_bus.buffer_index);
          check_field("processed_valid", want.proc_vld, rsp_bus.processed_valid);
          check_field("processed_index", want.proc_idx, rsp_bus.processed_index);
          check_field("client_status", want.status, rsp_bus.client_status);
          check_field("outstanding", want.held, rsp_bus.outstanding);
        end
        rx_stall = rx_idle ? $urandom_range(0, 4) : 0;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : run_test
    logic [CNT_W-1:0] ring_plan [PHASES];
    int               phase;
    int               k;
    ring_plan = '{5'd16, 5'd1, 5'd7, 5'd16, 5'd2, 5'd1, 5'd12, 5'd16};
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    req_bus.valid           = 1'b0;
    req_bus.operation       = '0;
    req_bus.client          = '0;
    req_bus.returned_buffer = '0;
    rsp_bus.ready           = 1'b0;
    tx_idle  = 1'b1;
    rx_idle  = 1'b1;
    live_cfg = BUFFER_COUNT_RST;
    plan_cfg = BUFFER_COUNT_RST;
    for (k = 0; k < CLIENTS; k++) begin
      live_ring[k] = '{status: STAT_CLOSED, dptr: '0, rptr: '0, held: '0};
      plan_ring[k] = live_ring[k];
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: every operation on a closed client, reopen while closing, full ring, wrong and last returns
    push_req(OP_FEEDBACK, 0, 15);
    push_req(OP_CLOSE, 0, 0);
    push_req(OP_CONTINUE, 0, 0);
    push_req(OP_OPEN, 0, 0);
    push_req(OP_OPEN, 0, 0);
    push_req(OP_CLOSE, 0, 0);
    push_req(OP_OPEN, 0, 0);
    push_req(OP_CONTINUE, 0, 0);
    push_req(OP_FEEDBACK, 0, 0);
    for (k = 0; k < 4; k++) push_req(OP_CONTINUE, 0, 0);
    push_req(OP_FEEDBACK, 0, 3);
    push_req(OP_FEEDBACK, 0, 0);
    push_req(OP_CONTINUE, 0, 0);
    push_req(OP_CLOSE, 0, 0);
    push_req(OP_OPEN, 0, 0);
    push_req(OP_CLOSE, 0, 0);
    for (k = 1; k <= 4; k++) push_req(OP_FEEDBACK, 0, k % 4);
    push_req(OP_OPEN, CLIENTS - 1, 15);
    push_req(OP_CLOSE, CLIENTS - 1, 15);

    // Random phases; the ring size changes while streams are still open
    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      tx_idle <= (phase % 4) < 2;
      rx_idle <= (phase % 2) == 0;
      write_ring_size(ring_plan[phase]);
      @(negedge clk_i);
      plan_cfg = ring_plan[phase];
      for (k = 0; k < PHASE_ITEMS; k++) pick_request();
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
